/* hdl/lptg_pkg.sv */
// Shared constants and types for the looping playback tick generator.
`default_nettype none
package lptg_pkg;

    localparam int TIME_BITS_DEF = 48;     // wall-time arithmetic width
    localparam int NOW_W         = 48;     // now_msecs field
    localparam int MODE_W        = 2;
    localparam int TICK_W        = 32;
    localparam int RATE_W        = 16;

    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 3;

    localparam int MS_PER_S      = 1000;
    localparam int RESYNC_SECS   = 30;
    localparam int SAT_EXP       = 46;     // elapsed ms of 2^46 or more scale to 2^46 ticks

    // serial arithmetic units
    localparam int MUL_A_W       = SAT_EXP;
    localparam int MUL_B_W       = RATE_W;
    localparam int DVD_W         = MUL_A_W + MUL_B_W;
    localparam int DVS_W         = TICK_W;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TICK  = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_UPDATE = 2'd0,
        MODE_START  = 2'd1,
        MODE_STOP   = 2'd2
    } mode_t;

endpackage
`default_nettype wire

/* hdl/lptg_if.sv */
// Valid/ready channel interfaces for command items and tick results.
`default_nettype none
interface lptg_in_if;
    logic                             valid;
    logic                             ready;
    logic [lptg_pkg::MODE_W-1:0]      mode;
    logic [lptg_pkg::NOW_W-1:0]       now_msecs;

    modport source (output valid, mode, now_msecs, input ready);
    modport sink   (input valid, mode, now_msecs, output ready);
endinterface

interface lptg_out_if;
    logic                             valid;
    logic                             ready;
    logic                             tick_valid;
    logic signed [lptg_pkg::TICK_W-1:0] tick_value;
    logic                             stop_request;

    modport source (output valid, tick_valid, tick_value, stop_request, input ready);
    modport sink   (input valid, tick_valid, tick_value, stop_request, output ready);
endinterface
`default_nettype wire

/* hdl/lptg_mul.sv */
// Serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module lptg_mul #(
    parameter int A_W = lptg_pkg::MUL_A_W,
    parameter int B_W = lptg_pkg::MUL_B_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic                    done,
    output logic [A_W+B_W-1:0]      product
);
    import lptg_pkg::*;

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [A_W-1:0]   hi_reg;
    logic [B_W-1:0]   lo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W:0]     sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                hi_reg   <= '0;
                lo_reg   <= b;
                cnt_reg  <= CNT_W'(B_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                hi_reg  <= sum[A_W:1];
                lo_reg  <= {sum[0], lo_reg[B_W-1:1]};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule
`default_nettype wire

/* hdl/lptg_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module lptg_div #(
    parameter int DVD_W = lptg_pkg::DVD_W,
    parameter int DVS_W = lptg_pkg::DVS_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [DVD_W-1:0]           dividend,   // left aligned
    input  wire logic [DVS_W-1:0]           divisor,
    input  wire logic [$clog2(DVD_W+1)-1:0] count,      // quotient bits wanted
    output logic                            done,
    output logic [DVD_W-1:0]                quotient,   // low count bits valid
    output logic [DVS_W-1:0]                remainder
);
    import lptg_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= count;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
                rem_reg <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

/* hdl/looping_playback_tick_generator_top.sv */
// Start, stop, unused modes and updates while stopped go from idle straight to the finish state
// and the output register; a time update runs the serial multiply by the rate and the serial
// divide by 1000; a resync adds a multiply by 1000 and a divide by the rate, a loop wrap a modulo divide.
// Throughput: one transfer at a time; the next command is taken once the result is
// registered, even while that result still waits on the output side.
// Reset: asynchronous, active low; clears registers, playback state and the output.
`default_nettype none
module looping_playback_tick_generator_top #(
    parameter int TIME_BITS = lptg_pkg::TIME_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lptg_in_if.sink                              req,
    lptg_out_if.source                           rsp,
    input  wire logic                            cfg_write,
    input  wire logic [lptg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lptg_pkg::CFG_W-1:0]      cfg_data
);
    import lptg_pkg::*;

    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int SUM_W     = DVD_W + 2;
    localparam int LIM_W     = RATE_W + 6;         // holds 30 * rate
    localparam int BACK_W    = TICK_W + 10;        // |tick delta| * 1000
    localparam logic [DVD_W-1:0] SAT_SCALED =
        {{(DVD_W-SAT_EXP-1){1'b0}}, 1'b1, {SAT_EXP{1'b0}}};
    localparam logic signed [TICK_W-1:0] TICK_MAX = {1'b0, {(TICK_W-1){1'b1}}};
    localparam logic signed [TICK_W-1:0] TICK_MIN = {1'b1, {(TICK_W-1){1'b0}}};

    // sequencer: elapsed time -> scale -> resync check -> loop check -> commit
    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,     // now - origin
        S_MAG,      // sign and magnitude of the difference
        S_SCALE,    // zero rate / clamp / launch multiply
        S_MUL_T,    // ms * rate
        S_DIV_T,    // / 1000
        S_SUM,      // start_tick +/- scaled, saturated
        S_JUMP,     // fresh - last
        S_CHECK,    // compare against 30 s of ticks
        S_BACK_D,   // last - start
        S_BACK_M,   // |last - start| * 1000
        S_MUL_B,
        S_DIV_B,    // / rate
        S_ORIGIN,   // move origin to hold the tick
        S_LOOP,     // loop end handling
        S_MOD,      // wrap by modulo
        S_COMMIT,
        S_FINISH    // wait for the output register
    } state_t;

    state_t                      state_reg;

    // configuration
    logic [RATE_W-1:0]           rate_reg;
    logic                        loop_en_reg;
    logic signed [TICK_W-1:0]    loop_start_reg;
    logic signed [TICK_W-1:0]    loop_end_reg;
    logic signed [TICK_W-1:0]    start_tick_reg;

    // playback state
    logic                        playing_reg;
    logic [TIME_BITS-1:0]        origin_reg;
    logic signed [TICK_W-1:0]    last_reg;

    // working registers
    logic [TIME_BITS-1:0]        now_reg;
    logic [TIME_BITS-1:0]        mag_reg;
    logic                        neg_reg;
    logic [DVD_W-1:0]            scaled_reg;
    logic signed [TICK_W-1:0]    fresh_reg;
    logic signed [TICK_W:0]      delta_reg;
    logic                        res_valid_reg;
    logic                        res_stop_reg;

    // output register
    logic                        out_valid_reg;
    logic                        out_tick_valid_reg;
    logic signed [TICK_W-1:0]    out_tick_reg;
    logic                        out_stop_reg;
    logic                        out_load;

    // serial units
    logic                        mul_start;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic                        mul_done;
    logic [DVD_W-1:0]            mul_product;
    logic                        div_start;
    logic [DVD_W-1:0]            div_dvd;
    logic [DVS_W-1:0]            div_dvs;
    logic [DIV_CNT_W-1:0]        div_cnt;
    logic                        div_done;
    logic [DVD_W-1:0]            div_quo;
    logic [DVS_W-1:0]            div_rem;

    // datapath
    logic [63:0]                 mag_ext;
    logic                        mag_sat;
    logic [SUM_W-1:0]            start_ext;
    logic [SUM_W-1:0]            scaled_ext;
    logic [SUM_W-1:0]            sum;
    logic [SUM_W-TICK_W:0]       sum_top;
    logic signed [TICK_W-1:0]    sum_sat;
    logic [LIM_W-1:0]            lim;
    logic signed [TICK_W:0]      lim_s;
    logic                        big_jump;
    logic [TICK_W:0]             delta_mag;
    logic                        past_end;
    logic                        wrap_go;
    logic signed [TICK_W:0]      off;
    logic signed [TICK_W:0]      dur;
    logic [BACK_W-1:0]           back_q;

    lptg_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    lptg_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .count     (div_cnt),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // elapsed magnitude of 2^46 ms or more saturates the scaled ticks to 2^46
    assign mag_ext = 64'(mag_reg);
    assign mag_sat = |mag_ext[63:SAT_EXP];

    // start_tick +/- scaled ticks, saturated to 32 bits signed
    assign start_ext  = {{(SUM_W-TICK_W){start_tick_reg[TICK_W-1]}}, start_tick_reg};
    assign scaled_ext = SUM_W'(scaled_reg);
    assign sum        = neg_reg ? start_ext - scaled_ext : start_ext + scaled_ext;
    assign sum_top    = sum[SUM_W-1:TICK_W-1];

    always_comb
    begin
        if ((&sum_top) || !(|sum_top))
            sum_sat = sum[TICK_W-1:0];
        else if (sum[SUM_W-1])
            sum_sat = TICK_MIN;
        else
            sum_sat = TICK_MAX;
    end

    // resync threshold: 30 s worth of ticks = 32r - 2r
    assign lim      = (LIM_W'(rate_reg) << 5) - (LIM_W'(rate_reg) << 1);
    assign lim_s    = {{(TICK_W+1-LIM_W){1'b0}}, lim};
    assign big_jump = (delta_reg > lim_s) || (delta_reg < -lim_s);

    assign delta_mag = delta_reg[TICK_W] ? unsigned'(-delta_reg) : unsigned'(delta_reg);

    // loop end: fresh sits in [loop_end, 2^31) so both differences are non-negative
    assign past_end = (loop_end_reg > 0) && (fresh_reg >= loop_end_reg);
    assign wrap_go  = past_end && loop_en_reg && (loop_end_reg > loop_start_reg);
    assign off      = {fresh_reg[TICK_W-1], fresh_reg}
                    - {loop_start_reg[TICK_W-1], loop_start_reg};
    assign dur      = {loop_end_reg[TICK_W-1], loop_end_reg}
                    - {loop_start_reg[TICK_W-1], loop_start_reg};

    assign back_q = div_quo[BACK_W-1:0];

    // output register takes a new result when empty or when its transfer completes
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    // unit launches; each unit latches its operands on start
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = MUL_A_W'(delta_mag);
        mul_b     = MUL_B_W'(MS_PER_S);
        div_start = 1'b0;
        div_dvd   = mul_product;
        div_dvs   = DVS_W'(MS_PER_S);
        div_cnt   = DIV_CNT_W'(DVD_W);
        unique case (state_reg)
            S_SCALE:
            begin
                mul_start = (rate_reg != '0) && !mag_sat;
                mul_a     = mag_ext[MUL_A_W-1:0];
                mul_b     = rate_reg;
            end
            S_BACK_M:
            begin
                mul_start = 1'b1;
            end
            S_MUL_T:
            begin
                div_start = mul_done;
            end
            S_MUL_B:
            begin
                div_start = mul_done;
                div_dvd   = {mul_product[BACK_W-1:0], {(DVD_W-BACK_W){1'b0}}};
                div_dvs   = DVS_W'(rate_reg);
                div_cnt   = DIV_CNT_W'(BACK_W);
            end
            S_LOOP:
            begin
                div_start = wrap_go;
                div_dvd   = {off[DVS_W-1:0], {(DVD_W-DVS_W){1'b0}}};
                div_dvs   = dur[DVS_W-1:0];
                div_cnt   = DIV_CNT_W'(DVS_W);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            rate_reg           <= '0;
            loop_en_reg        <= 1'b0;
            loop_start_reg     <= '0;
            loop_end_reg       <= '0;
            start_tick_reg     <= '0;
            playing_reg        <= 1'b0;
            origin_reg         <= '0;
            last_reg           <= '0;
            now_reg            <= '0;
            mag_reg            <= '0;
            neg_reg            <= 1'b0;
            scaled_reg         <= '0;
            fresh_reg          <= '0;
            delta_reg          <= '0;
            res_valid_reg      <= 1'b0;
            res_stop_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_tick_valid_reg <= 1'b0;
            out_tick_reg       <= '0;
            out_stop_reg       <= 1'b0;
        end
        else
        begin
            // configuration writes: the user must issue them only while idle; the block does not enforce it
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TICK_RATE:   rate_reg       <= cfg_data[RATE_W-1:0];
                    CFG_LOOP_ENABLE: loop_en_reg    <= cfg_data[0];
                    CFG_LOOP_START:  loop_start_reg <= cfg_data[TICK_W-1:0];
                    CFG_LOOP_END:    loop_end_reg   <= cfg_data[TICK_W-1:0];
                    CFG_START_TICK:  start_tick_reg <= cfg_data[TICK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        res_valid_reg <= 1'b0;
                        res_stop_reg  <= 1'b0;
                        now_reg       <= TIME_BITS'(req.now_msecs);
                        unique case (mode_t'(req.mode))
                            MODE_START:
                            begin
                                origin_reg  <= TIME_BITS'(req.now_msecs);
                                last_reg    <= start_tick_reg;
                                playing_reg <= 1'b1;
                                state_reg   <= S_FINISH;
                            end
                            MODE_STOP:
                            begin
                                playing_reg <= 1'b0;
                                state_reg   <= S_FINISH;
                            end
                            MODE_UPDATE:
                            begin
                                state_reg <= playing_reg ? S_DIFF : S_FINISH;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_DIFF:
                begin
                    mag_reg   <= now_reg - origin_reg;
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    // difference wraps modulo 2^TIME_BITS and reads as signed
                    neg_reg   <= mag_reg[TIME_BITS-1];
                    mag_reg   <= mag_reg[TIME_BITS-1] ? -mag_reg : mag_reg;
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    if (rate_reg == '0)
                    begin
                        scaled_reg <= '0;
                        state_reg  <= S_SUM;
                    end
                    else if (mag_sat)
                    begin
                        scaled_reg <= SAT_SCALED;
                        state_reg  <= S_SUM;
                    end
                    else
                        state_reg <= S_MUL_T;
                end
                S_MUL_T:
                begin
                    if (mul_done)
                        state_reg <= S_DIV_T;
                end
                S_DIV_T:
                begin
                    if (div_done)
                    begin
                        scaled_reg <= div_quo;
                        state_reg  <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    fresh_reg <= sum_sat;
                    state_reg <= S_JUMP;
                end
                S_JUMP:
                begin
                    delta_reg <= {fresh_reg[TICK_W-1], fresh_reg}
                               - {last_reg[TICK_W-1], last_reg};
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (big_jump)
                    begin
                        // hold the tick; move the origin only for a nonzero rate
                        fresh_reg <= last_reg;
                        state_reg <= (rate_reg != '0) ? S_BACK_D : S_LOOP;
                    end
                    else
                        state_reg <= S_LOOP;
                end
                S_BACK_D:
                begin
                    delta_reg <= {last_reg[TICK_W-1], last_reg}
                               - {start_tick_reg[TICK_W-1], start_tick_reg};
                    state_reg <= S_BACK_M;
                end
                S_BACK_M:
                begin
                    neg_reg   <= delta_reg[TICK_W];
                    state_reg <= S_MUL_B;
                end
                S_MUL_B:
                begin
                    if (mul_done)
                        state_reg <= S_DIV_B;
                end
                S_DIV_B:
                begin
                    if (div_done)
                        state_reg <= S_ORIGIN;
                end
                S_ORIGIN:
                begin
                    // back-off truncates toward zero: magnitude quotient, sign reapplied
                    origin_reg <= neg_reg ? now_reg + TIME_BITS'(back_q)
                                          : now_reg - TIME_BITS'(back_q);
                    state_reg  <= S_LOOP;
                end
                S_LOOP:
                begin
                    if (wrap_go)
                        state_reg <= S_MOD;
                    else
                    begin
                        if (past_end && !loop_en_reg)
                            res_stop_reg <= 1'b1;
                        state_reg <= S_COMMIT;
                    end
                end
                S_MOD:
                begin
                    if (div_done)
                    begin
                        fresh_reg <= loop_start_reg + signed'(div_rem);
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (fresh_reg != last_reg)
                    begin
                        last_reg      <= fresh_reg;
                        res_valid_reg <= 1'b1;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_tick_valid_reg <= res_valid_reg;
                        out_tick_reg       <= last_reg;
                        out_stop_reg       <= res_stop_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.tick_valid   = out_tick_valid_reg;
    assign rsp.tick_value   = out_tick_reg;
    assign rsp.stop_request = out_stop_reg;

endmodule
`default_nettype wire

/* tb/sv/lptg_tick_checker.sv */
// Tick checker: mirrors the register file, predicts each tick result and compares transfers.
`timescale 1ns / 100ps
module lptg_tick_checker
    import lptg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lptg_in_if                   req,
    lptg_out_if                  rsp,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct packed {
        logic                     tick_valid;
        logic signed [TICK_W-1:0] tick_value;
        logic                     stop_request;
    } tick_result_t;

    // mirrored registers
    logic [RATE_W-1:0]        rate_q;
    logic                     loop_en_q;
    logic signed [TICK_W-1:0] loop_start_q;
    logic signed [TICK_W-1:0] loop_end_q;
    logic signed [TICK_W-1:0] start_tick_q;

    // playback state
    logic                     playing;
    logic [NOW_W-1:0]         origin_ms;
    logic signed [TICK_W-1:0] last_tick;

    tick_result_t due_q[$];
    int           errs;

    // signed ticks elapsed since the origin; the ms difference wraps, and 2^46 ms or more gives 2^46 ticks
    function automatic longint scaled_elapsed(input logic [NOW_W-1:0] now);
        logic [NOW_W-1:0]  diff;
        logic [NOW_W-1:0]  mag;
        longint unsigned   m;
        longint unsigned   prod;
        diff = now - origin_ms;
        mag  = diff[NOW_W-1] ? (~diff + 1'b1) : diff;
        if (rate_q == '0)
            return 0;
        m = mag;
        if (|mag[NOW_W-1:SAT_EXP])
            prod = 64'd1 << SAT_EXP;
        else
            prod = m * rate_q / MS_PER_S;
        return diff[NOW_W-1] ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic tick_result_t advance(input logic [MODE_W-1:0] mode,
                                             input logic [NOW_W-1:0]  now);
        tick_result_t r;
        longint       fresh;
        longint       jump;
        longint       back;
        longint       span;
        r = '0;
        case (mode)
            MODE_START:
            begin
                origin_ms = now;
                last_tick = start_tick_q;
                playing   = 1'b1;
            end
            MODE_STOP:
                playing = 1'b0;
            MODE_UPDATE:
                if (playing)
                begin
                    fresh = longint'(start_tick_q) + scaled_elapsed(now);
                    if (fresh > 64'sh7FFF_FFFF)
                        fresh = 64'sh7FFF_FFFF;
                    else if (fresh < -64'sh8000_0000)
                        fresh = -64'sh8000_0000;
                    jump = fresh - longint'(last_tick);
                    if (jump < 0)
                        jump = -jump;
                    // too far from the last tick: pull the origin so the tick holds
                    if (jump > RESYNC_SECS * longint'(rate_q))
                    begin
                        if (rate_q != '0)
                        begin
                            back = (longint'(last_tick) - longint'(start_tick_q)) * MS_PER_S
                                   / longint'(rate_q);
                            origin_ms = now - back[NOW_W-1:0];
                        end
                        fresh = last_tick;
                    end
                    if (loop_end_q > 0 && fresh >= loop_end_q)
                    begin
                        if (loop_en_q)
                        begin
                            span = longint'(loop_end_q) - longint'(loop_start_q);
                            if (span > 0)
                                fresh = (fresh - loop_start_q) % span + loop_start_q;
                        end
                        else
                            r.stop_request = 1'b1;
                    end
                    if (fresh != last_tick)
                    begin
                        last_tick    = fresh[TICK_W-1:0];
                        r.tick_valid = 1'b1;
                    end
                end
            default: ;
        endcase
        r.tick_value = last_tick;
        return r;
    endfunction

    task automatic flag(input string what, input longint want, input longint got);
        errs++;
        $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            rate_q       = '0;
            loop_en_q    = 1'b0;
            loop_start_q = '0;
            loop_end_q   = '0;
            start_tick_q = '0;
            playing      = 1'b0;
            origin_ms    = '0;
            last_tick    = '0;
            errs         = 0;
            due_q.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_write)
                case (cfg_index)
                    CFG_TICK_RATE:   rate_q       = cfg_data[RATE_W-1:0];
                    CFG_LOOP_ENABLE: loop_en_q    = cfg_data[0];
                    CFG_LOOP_START:  loop_start_q = cfg_data[TICK_W-1:0];
                    CFG_LOOP_END:    loop_end_q   = cfg_data[TICK_W-1:0];
                    CFG_START_TICK:  start_tick_q = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            if (rsp.valid && rsp.ready)
            begin
                if (due_q.size() == 0)
                begin
                    errs++;
                    $display("%0t ns: result with nothing expected, tick_value %0d",
                             $time, rsp.tick_value);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (rsp.tick_valid !== want.tick_valid)
                        flag("tick_valid", want.tick_valid, rsp.tick_valid);
                    if (rsp.tick_value !== want.tick_value)
                        flag("tick_value", longint'($signed(want.tick_value)),
                             longint'(rsp.tick_value));
                    if (rsp.stop_request !== want.stop_request)
                        flag("stop_request", want.stop_request, rsp.stop_request);
                end
            end
            if (req.valid && req.ready)
                due_q.insert(due_q.size(), advance(req.mode, req.now_msecs));
            outstanding <= due_q.size();
            fail_count  <= errs;
        end
    end

endmodule

/* tb/sv/looping_playback_tick_generator_top_tb.sv */
// Testbench top: drives commands and register writes into the tick generator, gives the verdict.
`timescale 1ns / 100ps
module looping_playback_tick_generator_top_tb;
    import lptg_pkg::*;

    // mode 3 has no meaning; the block must answer with a quiet result
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam longint TICK_MAX    = 64'sh7FFF_FFFF;
    localparam longint TICK_MIN    = -TICK_MAX - 1;
    localparam int     PHASES      = 10;
    localparam int     PHASE_ITEMS = 165;
    localparam int     STEADY_PH   = 5;       // phase run with no idling on either side
    localparam int     IDLE_PCT    = 26;
    localparam int     QUIET       = 8;       // cycles left after a drain before a register write
    localparam int     TAIL_CYCLES = 200;     // update + resync + wrap, with margin
    // worst-case transfer plus stalls over ~1700 transfers, with a wide margin
    localparam int     CYCLE_LIMIT = 1_500_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   outstanding;
    bit                   steady;
    logic [NOW_W-1:0]     clock_ms;           // wall clock as the sender sees it
    int                   sent;
    int                   settings;
    int                   cycles;

    lptg_in_if  req_ch ();
    lptg_out_if rsp_ch ();

    looping_playback_tick_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lptg_tick_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure: ready drops in about a quarter of cycles,
    // except through the steady phase.
    always @(posedge clk)
        rsp_ch.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);

    // Run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [TICK_W-1:0] to_tick(input longint v);
        longint c;
        c = (v > TICK_MAX) ? TICK_MAX : (v < TICK_MIN) ? TICK_MIN : v;
        return c[TICK_W-1:0];
    endfunction

    // One command transfer. An optional gap first; valid stays high after the
    // transfer so back-to-back commands need no extra edge.
    task automatic issue(input logic [MODE_W-1:0] m, input logic [NOW_W-1:0] t);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= m;
        req_ch.now_msecs <= t;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sent++;
    endtask

    // Hold the sender until every predicted result has been seen. The first
    // edge lets the checker count a transfer taken on this very edge.
    task automatic drain(input int tail);
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (tail) @(posedge clk);
    endtask

    // Writes all five registers on consecutive edges; block must be idle.
    task automatic program_regs(input logic [RATE_W-1:0]     rate,
                                input logic                  en,
                                input logic signed [TICK_W-1:0] ls,
                                input logic signed [TICK_W-1:0] le,
                                input logic signed [TICK_W-1:0] st);
        cfg_write <= 1'b1;
        cfg_index <= CFG_TICK_RATE;
        cfg_data  <= CFG_W'(rate);
        @(posedge clk);
        cfg_index <= CFG_LOOP_ENABLE;
        cfg_data  <= CFG_W'(en);
        @(posedge clk);
        cfg_index <= CFG_LOOP_START;
        cfg_data  <= ls;
        @(posedge clk);
        cfg_index <= CFG_LOOP_END;
        cfg_data  <= le;
        @(posedge clk);
        cfg_index <= CFG_START_TICK;
        cfg_data  <= st;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    // Settings for one random phase. Phase 0 sits on the extremes; the rest
    // mix real loops, disabled ends, empty loops and raw random values.
    task automatic random_settings(input int p);
        logic [RATE_W-1:0] rate;
        logic              en;
        longint            st;
        longint            le;
        longint            ls;
        if (p == 0)
            program_regs(16'hFFFF, 1'b1, to_tick(TICK_MIN), to_tick(TICK_MAX),
                         to_tick(TICK_MAX - 2000000));
        else
        begin
            if (p == 1)
                rate = '0;
            else if (p == 2)
                rate = 16'd1;
            else if ($urandom_range(2) == 0)
                rate = RATE_W'($urandom_range(2, 2000));
            else
                rate = RATE_W'($urandom_range(1, 65535));
            en = 1'($urandom_range(1));
            case ($urandom_range(3))
                0:       st = 0;
                1:       st = int'($urandom);
                2:       st = TICK_MAX - $urandom_range(0, 100000);
                default: st = TICK_MIN + $urandom_range(0, 100000);
            endcase
            case ($urandom_range(3))
                0:
                begin
                    // reachable loop inside the ticks this phase will cover
                    le = st + $urandom_range(1, 40 * rate + 100);
                    ls = le - $urandom_range(1, 20 * rate + 50);
                end
                1:
                begin
                    // end check disabled
                    le = -longint'($urandom_range(0, 1000));
                    ls = int'($urandom);
                end
                2:
                begin
                    // empty or inverted loop
                    le = st + $urandom_range(1, 1000);
                    ls = le + $urandom_range(0, 5000);
                end
                default:
                begin
                    le = int'($urandom);
                    ls = int'($urandom);
                end
            endcase
            program_regs(rate, en, to_tick(ls), to_tick(le), to_tick(st));
        end
    endtask

    // Mostly a playing player fed a steadily advancing clock, with restarts,
    // stops, backward steps, long jumps and the odd unused mode mixed in.
    task automatic play_phase(input int n_items);
        int          counted;
        int          pick;
        logic [63:0] wide;
        counted = 0;
        if ($urandom_range(3) == 0)
        begin
            wide     = {$urandom, $urandom};
            clock_ms = wide[NOW_W-1:0];
        end
        issue(MODE_START, clock_ms);
        counted++;
        while (counted < n_items)
        begin
            pick = $urandom_range(999);
            if (pick < 30)
                issue(MODE_START, clock_ms);
            else if (pick < 40)
                issue(MODE_STOP, clock_ms);
            else if (pick < 55)
            begin
                wide = {$urandom, $urandom};
                issue(MODE_UNUSED, wide[NOW_W-1:0]);
            end
            else
            begin
                if (pick < 80)
                begin
                    wide     = {$urandom, $urandom};
                    clock_ms = wide[NOW_W-1:0];
                end
                else if (pick < 120)
                    clock_ms -= $urandom_range(1, 3000);
                else if (pick < 170)
                    clock_ms += $urandom_range(30000, 200000);
                else
                    clock_ms += $urandom_range(0, 250);
                issue(MODE_UPDATE, clock_ms);
            end
            counted++;
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_UPDATE;
        req_ch.now_msecs = '0;
        cfg_write        = 1'b0;
        cfg_index        = CFG_TICK_RATE;
        cfg_data         = '0;
        steady           = 1'b0;
        clock_ms         = '0;
        sent             = 0;
        settings         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: rate zero, so the tick never moves
        issue(MODE_UPDATE, 48'd5);             // stopped: quiet result
        issue(MODE_START, '0);
        issue(MODE_UPDATE, '1);                // latest possible time, still no change
        issue(MODE_UNUSED, 48'd123);
        issue(MODE_STOP, 48'd7);
        issue(MODE_UPDATE, 48'd9);
        drain(QUIET);

        // One tick per millisecond, end check off
        program_regs(16'd1000, 1'b0, '0, '0, '0);
        issue(MODE_START, 48'd1000);
        issue(MODE_UPDATE, 48'd1500);
        issue(MODE_UPDATE, 48'd500);           // before the origin: negative ticks
        issue(MODE_UPDATE, 48'd40000);         // over 30 s of ticks: resync, tick held
        issue(MODE_UPDATE, 48'd40600);
        issue(MODE_START, '1);                 // restart while playing
        issue(MODE_UPDATE, 48'd5);             // wall clock wrapped past zero
        drain(QUIET);

        // Full rate just below the top tick, end at the top, no looping
        program_regs(16'hFFFF, 1'b0, '0, to_tick(TICK_MAX), to_tick(TICK_MAX - 100));
        issue(MODE_START, '0);
        issue(MODE_UPDATE, 48'd1);
        issue(MODE_UPDATE, 48'h7FFF_FFFF_FFFF); // clamped elapsed, saturated sum, stop request
        issue(MODE_UPDATE, 48'h7FFF_FFFF_FFFF); // stop request again while still playing
        issue(MODE_STOP, 48'd2);
        drain(QUIET);

        // Zero rate past the loop end: one wrap, then a resync that leaves the origin
        program_regs('0, 1'b1, 32'sd100, 32'sd1000, 32'sd5000);
        issue(MODE_START, '0);
        issue(MODE_UPDATE, 48'd10);
        issue(MODE_UPDATE, 48'd20);
        drain(QUIET);

        // Inverted loop: past the end, no wrap and no stop
        program_regs(16'd1000, 1'b1, 32'sd2000, 32'sd1000, '0);
        issue(MODE_START, '0);
        issue(MODE_UPDATE, 48'd1500);
        drain(QUIET);

        for (int p = 0; p < PHASES; p++)
        begin
            random_settings(p);
            if (p == STEADY_PH)
                steady <= 1'b1;
            play_phase(PHASE_ITEMS);
            if (p == STEADY_PH)
                steady <= 1'b0;
            drain(p == PHASES - 1 ? TAIL_CYCLES : QUIET);
        end

        $display("Run covered %0d command transfers over %0d register settings,", sent, settings);
        $display("with restarts, resyncs, loop wraps, stop requests and clock wrap-around.");
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lptg_pkg.sv
hdl/lptg_if.sv
hdl/lptg_mul.sv
hdl/lptg_div.sv
hdl/looping_playback_tick_generator_top.sv
tb/sv/lptg_tick_checker.sv
tb/sv/looping_playback_tick_generator_top_tb.sv
